// ----- rtl/core/plm_pkg.sv -----
// plm_pkg: widths, constants and the per-cycle command struct for the positional list engine.
// Used by plm_cell and positional_list_engine; no dependencies.
`default_nettype none

package plm_pkg;

  localparam int DATA_W        = 32;
  localparam int POS_W         = 8;
  localparam int COUNT_W       = 5;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] slot;
  } plm_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/plm_cell.sv -----
// plm_cell: one list slot; loads a new value or shifts from a neighbour on each edit.
// Depends on plm_pkg for widths and the command struct.
`default_nettype none

module plm_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic                     clk,
  input  wire plm_pkg::plm_cmd_t        cmd,
  input  wire logic [plm_pkg::DATA_W-1:0] new_value,
  input  wire logic [plm_pkg::DATA_W-1:0] left_value,
  input  wire logic [plm_pkg::DATA_W-1:0] right_value,
  output logic      [plm_pkg::DATA_W-1:0] value,
  output logic      [plm_pkg::DATA_W-1:0] sel_value
);

  localparam logic [plm_pkg::POS_W-1:0] MY_IDX = plm_pkg::POS_W'(CELL_IDX);

  logic [plm_pkg::DATA_W-1:0] value_r;
  logic [plm_pkg::DATA_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (cmd.ins) begin
      if (MY_IDX == cmd.slot) begin
        value_nxt = new_value;
      end else if (MY_IDX > cmd.slot) begin
        value_nxt = left_value;
      end
    end else if (cmd.rem) begin
      if (MY_IDX >= cmd.slot) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value     = value_r;
  assign sel_value = (MY_IDX == cmd.slot) ? value_r : '0;

endmodule

`default_nettype wire

// ----- rtl/core/positional_list_engine.sv -----
// positional_list_engine: bounded ordered list of signed values edited by 1-based position.
// Depends on plm_pkg and plm_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries in_func (0 insert, 1 remove), in_position
//   (1-based) and in_value. Result channel out_valid/out_ready returns out_ok,
//   out_removed_value (0 unless a remove succeeded) and out_count, the element count
//   after the transaction. Exactly one result per input transaction, in order.
//   Every cell of the row decides on its own whether to load the new value, take
//   its left neighbour (insert) or its right neighbour (remove), so an edit at any
//   position is applied to the whole row at once.
//   Latency: the result is valid in the cycle after the input transaction.
//   Throughput: one transaction per cycle while out_ready is high; the single
//   output register is the only buffer, so in_ready follows out_ready when it holds
//   a result.
//   Reset (rst_n low, synchronous) empties the list and drops out_valid; cell
//   contents and result fields are not cleared, and cells are never read before
//   being written.
//   When the receiver stalls, the result is held and in_ready drops until it is taken.
`default_nettype none

module positional_list_engine #(
  parameter int DEPTH = plm_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_func,
  input  wire logic        [plm_pkg::POS_W-1:0]  in_position,
  input  wire logic signed [plm_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_ok,
  output logic signed      [plm_pkg::DATA_W-1:0] out_removed_value,
  output logic             [plm_pkg::COUNT_W-1:0] out_count
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = plm_pkg::POS_W + 1;
  localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

  logic [OCC_W-1:0]           occ_r;
  logic [OCC_W-1:0]           occ_nxt;
  logic                       out_valid_r;
  logic                       out_ok_r;
  logic [plm_pkg::DATA_W-1:0] out_removed_value_r;
  logic [plm_pkg::COUNT_W-1:0] out_count_r;

  logic                       in_acc;
  logic [CMP_W-1:0]           pos_ext;
  logic [CMP_W-1:0]           occ_ext;
  logic                       ins_ok;
  logic                       rem_ok;
  plm_pkg::plm_cmd_t          cmd;
  logic [plm_pkg::DATA_W-1:0] cell_value [DEPTH];
  logic [plm_pkg::DATA_W-1:0] cell_sel   [DEPTH];
  logic [plm_pkg::DATA_W-1:0] picked_value;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign pos_ext  = CMP_W'(in_position);
  assign occ_ext  = CMP_W'(occ_r);

  assign ins_ok = in_acc && (in_func == plm_pkg::FUNC_INSERT) && (pos_ext != '0)
                  && (pos_ext <= occ_ext + CMP_W'(1)) && (occ_r < DEPTH_OCC);
  assign rem_ok = in_acc && (in_func == plm_pkg::FUNC_REMOVE) && (pos_ext != '0)
                  && (pos_ext <= occ_ext);

  assign cmd.ins  = ins_ok;
  assign cmd.rem  = rem_ok;
  assign cmd.slot = in_position - plm_pkg::POS_W'(1);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [plm_pkg::DATA_W-1:0] left_v;
    logic [plm_pkg::DATA_W-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_value[g+1];
    end
    plm_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .new_value   (in_value),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[g]),
      .sel_value   (cell_sel[g])
    );
  end

  always_comb begin
    picked_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked_value = picked_value | cell_sel[i];
    end
  end

  always_comb begin
    priority if (ins_ok) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (rem_ok) begin
      occ_nxt = occ_r - OCC_W'(1);
    end else begin
      occ_nxt = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_ok_r            <= ins_ok || rem_ok;
      out_removed_value_r <= rem_ok ? picked_value : '0;
      out_count_r         <= plm_pkg::COUNT_W'(occ_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_removed_value = out_removed_value_r;
  assign out_count         = out_count_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_OCC)
    else $error("occupancy above depth");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> occ_r == $past(occ_r) + OCC_W'(1))
    else $error("insert did not grow the list");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !ins_ok && !rem_ok) |=> occ_r == $past(occ_r))
    else $error("rejected transaction changed the list");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> out_removed_value_r == '0)
    else $error("rejected result carries a value");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> !in_acc || $past(in_acc) == 1'b0)
    else $error("accepted while result stalled");

endmodule

`default_nettype wire
